// File: src/mqttd_pkg.sv
`timescale 1ns / 1ps
package mqttd_pkg;

    localparam int LEN_W = 28;

    typedef enum logic [3:0] {
        PH_FIXHDR   = 4'd0,
        PH_REMLEN   = 4'd1,
        PH_STR_HI   = 4'd2,
        PH_STR_LO   = 4'd3,
        PH_STR_BYTE = 4'd4,
        PH_LEVEL    = 4'd5,
        PH_CFLAGS   = 4'd6,
        PH_KA_HI    = 4'd7,
        PH_KA_LO    = 4'd8,
        PH_PKT_HI   = 4'd9,
        PH_PKT_LO   = 4'd10,
        PH_PAYLOAD  = 4'd11,
        PH_QOS      = 4'd12,
        PH_RETCODE  = 4'd13,
        PH_SESSPRES = 4'd14,
        PH_OTHER    = 4'd15
    } t_phase;

    localparam logic [3:0] K_FIXHDR  = 4'd0;
    localparam logic [3:0] K_REMLEN  = 4'd1;
    localparam logic [3:0] K_STRLEN  = 4'd2;
    localparam logic [3:0] K_STRBYTE = 4'd3;
    localparam logic [3:0] K_LEVEL   = 4'd4;
    localparam logic [3:0] K_CFLAGS  = 4'd5;
    localparam logic [3:0] K_KA      = 4'd6;
    localparam logic [3:0] K_PKTID   = 4'd7;
    localparam logic [3:0] K_PAYLOAD = 4'd8;
    localparam logic [3:0] K_QOS     = 4'd9;
    localparam logic [3:0] K_RETCODE = 4'd10;
    localparam logic [3:0] K_SESS    = 4'd11;
    localparam logic [3:0] K_OTHER   = 4'd12;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_GROUPS  = 2'd1;
    localparam logic [1:0] E_MAXLEN  = 2'd2;
    localparam logic [1:0] E_OVERRUN = 2'd3;

    typedef struct packed {
        logic [3:0]       packet_type;
        logic [3:0]       header_flags;
        logic [3:0]       field_kind;
        logic [7:0]       field_index;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] length_value;
        logic [15:0]      packet_id;
        logic             end_of_field;
        logic             end_of_packet;
        logic [1:0]       error_code;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// File: src/mqtt_packet_deframer_core.sv
// A byte's tagged result is formed combinationally and registered in the result queue.
// Throughput: one byte per cycle unless the queue is full; the parser steps per byte.
// A two-entry result queue lets input flow on while the output stalls, until full.
// Reset is synchronous and active low; it returns the parser to the fixed header
// and sets the length limit to its largest value.
`timescale 1ns / 1ps
module mqtt_packet_deframer_core #(
    parameter int MAX_LEN_BYTES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [27:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // in_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // packet_type, header_flags, field_kind, field_index, data_byte, length_value,
    // packet_id, end_of_field, end_of_packet, error_code, zero fill
    output logic [79:0]  m_axis_tdata
);
    import mqttd_pkg::*;

    logic [LEN_W-1:0] r_max_len;
    t_result          w_res, w_q;
    logic             w_full, w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_len <= {LEN_W{1'b1}};
        else if (i_cfg_we) r_max_len <= i_cfg_wdata;
    end

    assign s_axis_tready = ~w_full;
    assign w_step = s_axis_tvalid & ~w_full;

    mqttd_parser #(.MAX_LEN_BYTES(MAX_LEN_BYTES)) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(s_axis_tdata),
        .i_max_len(r_max_len), .o_res(w_res)
    );

    mqttd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_step), .i_data(w_res),
        .o_full(w_full), .o_valid(m_axis_tvalid),
        .i_rd(m_axis_tvalid & m_axis_tready), .o_data(w_q)
    );

    assign m_axis_tdata = {4'b0000, w_q.error_code, w_q.end_of_packet, w_q.end_of_field,
                           w_q.packet_id, w_q.length_value, w_q.data_byte,
                           w_q.field_index, w_q.field_kind, w_q.header_flags,
                           w_q.packet_type};

endmodule

// File: src/mqttd_parser.sv
`timescale 1ns / 1ps
module mqttd_parser #(
    parameter int MAX_LEN_BYTES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [7:0]               i_byte,
    input  logic [mqttd_pkg::LEN_W-1:0] i_max_len,
    output mqttd_pkg::t_result       o_res
);
    import mqttd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_type, n_type, r_flags, n_flags;
    logic [LEN_W-1:0]  r_rem, n_rem, r_left, n_left;
    logic [2:0]        r_grp, n_grp;
    logic [15:0]       r_slen, n_slen, r_sleft, n_sleft, r_pid, n_pid;
    logic [7:0]        r_idx, n_idx;
    logic [LEN_W-1:0]  w_grp_val;
    logic [LEN_W-1:0]  w_left_dec;
    logic [15:0]       w_sleft_dec;
    logic [7:0]        w_idx_inc;
    t_phase            w_after_str, w_after_pid, w_body;

    assign w_left_dec  = r_left - LEN_W'(1);
    assign w_sleft_dec = r_sleft - 16'd1;
    assign w_idx_inc   = (r_idx == 8'hFF) ? r_idx : r_idx + 8'd1;
    assign w_grp_val   = LEN_W'({21'd0, i_byte[6:0]}) << (7 * r_grp[1:0]);

    always_comb begin
        case (r_type)
            4'd1, 4'd3: w_body = PH_STR_HI;
            4'd2: w_body = PH_SESSPRES;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: w_body = PH_PKT_HI;
            default: w_body = PH_OTHER;
        endcase
        case (r_type)
            4'd3: w_after_pid = PH_PAYLOAD;
            4'd8, 4'd10: w_after_pid = PH_STR_HI;
            4'd9: w_after_pid = PH_RETCODE;
            default: w_after_pid = PH_OTHER;
        endcase
        case (r_type)
            4'd1: w_after_str = (r_idx == 8'd0) ? PH_LEVEL :
                                (r_idx < 8'd5) ? PH_STR_HI : PH_OTHER;
            4'd3: w_after_str = (r_flags[2:1] != 2'd0) ? PH_PKT_HI : PH_PAYLOAD;
            4'd8: w_after_str = PH_QOS;
            4'd10: w_after_str = PH_STR_HI;
            default: w_after_str = PH_OTHER;
        endcase
    end

    always_comb begin
        logic       bump;
        logic [15:0] slo;
        bump = 1'b0;
        slo = {r_slen[15:8], i_byte};
        n_phase = r_phase; n_type = r_type; n_flags = r_flags; n_rem = r_rem;
        n_left = r_left; n_grp = r_grp; n_slen = r_slen; n_sleft = r_sleft;
        n_idx = r_idx; n_pid = r_pid;
        o_res.packet_type   = r_type;
        o_res.header_flags  = r_flags;
        o_res.field_kind    = K_OTHER;
        o_res.field_index   = r_idx;
        o_res.data_byte     = i_byte;
        o_res.length_value  = r_rem;
        o_res.packet_id     = r_pid;
        o_res.end_of_field  = 1'b0;
        o_res.end_of_packet = 1'b0;
        o_res.error_code    = E_NONE;
        case (r_phase)
            PH_FIXHDR: begin
                n_type = i_byte[7:4]; n_flags = i_byte[3:0];
                n_rem = '0; n_left = '0; n_grp = '0; n_slen = '0; n_sleft = '0;
                n_idx = '0; n_pid = '0;
                o_res.packet_type  = i_byte[7:4];
                o_res.header_flags = i_byte[3:0];
                o_res.field_kind   = K_FIXHDR;
                o_res.field_index  = 8'd0;
                o_res.length_value = '0;
                o_res.packet_id    = '0;
                o_res.end_of_field = 1'b1;
                n_phase = PH_REMLEN;
            end
            PH_REMLEN: begin
                n_rem = r_rem | w_grp_val;
                n_grp = r_grp + 3'd1;
                o_res.field_kind   = K_REMLEN;
                o_res.length_value = n_rem;
                if (i_byte[7]) begin
                    if (32'(n_grp) >= MAX_LEN_BYTES) begin
                        o_res.error_code = E_GROUPS;
                        n_phase = PH_FIXHDR;
                    end
                end else if (n_rem > i_max_len) begin
                    o_res.error_code = E_MAXLEN;
                    n_phase = PH_FIXHDR;
                end else begin
                    o_res.end_of_field = 1'b1;
                    n_left = n_rem;
                    if (n_rem == '0) begin
                        o_res.end_of_packet = 1'b1;
                        n_phase = PH_FIXHDR;
                    end else begin
                        n_phase = w_body;
                    end
                end
            end
            default: begin
                n_left = w_left_dec;
                case (r_phase)
                    PH_STR_HI: begin
                        o_res.field_kind = K_STRLEN;
                        n_slen = {i_byte, 8'd0};
                        o_res.length_value = LEN_W'(n_slen);
                        n_phase = PH_STR_LO;
                    end
                    PH_STR_LO: begin
                        o_res.field_kind = K_STRLEN;
                        n_slen = slo;
                        o_res.length_value = LEN_W'(slo);
                        if (LEN_W'(slo) > w_left_dec) begin
                            o_res.error_code = E_OVERRUN;
                            n_phase = PH_FIXHDR;
                        end else begin
                            o_res.end_of_field = 1'b1;
                            n_sleft = slo;
                            if (slo == 16'd0) begin
                                n_phase = w_after_str;
                                bump = (r_type == 4'd1) || (r_type == 4'd3) ||
                                       (r_type == 4'd10);
                            end else begin
                                n_phase = PH_STR_BYTE;
                            end
                        end
                    end
                    PH_STR_BYTE: begin
                        o_res.field_kind = K_STRBYTE;
                        o_res.length_value = LEN_W'(r_slen);
                        n_sleft = w_sleft_dec;
                        if (w_sleft_dec == 16'd0) begin
                            o_res.end_of_field = 1'b1;
                            n_phase = w_after_str;
                            bump = (r_type == 4'd1) || (r_type == 4'd3) ||
                                   (r_type == 4'd10);
                        end
                    end
                    PH_LEVEL: begin
                        o_res.field_kind = K_LEVEL; o_res.end_of_field = 1'b1;
                        n_phase = PH_CFLAGS;
                    end
                    PH_CFLAGS: begin
                        o_res.field_kind = K_CFLAGS; o_res.end_of_field = 1'b1;
                        n_phase = PH_KA_HI;
                    end
                    PH_KA_HI: begin
                        o_res.field_kind = K_KA; n_phase = PH_KA_LO;
                    end
                    PH_KA_LO: begin
                        o_res.field_kind = K_KA; o_res.end_of_field = 1'b1;
                        n_phase = PH_STR_HI;
                    end
                    PH_PKT_HI: begin
                        o_res.field_kind = K_PKTID; n_slen = {8'd0, i_byte};
                        n_phase = PH_PKT_LO;
                    end
                    PH_PKT_LO: begin
                        o_res.field_kind = K_PKTID; o_res.end_of_field = 1'b1;
                        n_pid = {r_slen[7:0], i_byte};
                        o_res.packet_id = n_pid;
                        n_phase = w_after_pid;
                    end
                    PH_PAYLOAD: o_res.field_kind = K_PAYLOAD;
                    PH_QOS: begin
                        o_res.field_kind = K_QOS; o_res.end_of_field = 1'b1;
                        bump = 1'b1; n_phase = PH_STR_HI;
                    end
                    PH_RETCODE: begin
                        o_res.field_kind = K_RETCODE; o_res.end_of_field = 1'b1;
                        bump = 1'b1;
                        n_phase = (r_type == 4'd9) ? PH_RETCODE : PH_OTHER;
                    end
                    PH_SESSPRES: begin
                        o_res.field_kind = K_SESS; o_res.end_of_field = 1'b1;
                        n_phase = PH_RETCODE;
                    end
                    default: begin
                        o_res.field_kind = K_OTHER; n_phase = PH_OTHER;
                    end
                endcase
                if (bump) n_idx = w_idx_inc;
                if (o_res.error_code == E_NONE && w_left_dec == '0) begin
                    o_res.end_of_packet = 1'b1;
                    if (o_res.field_kind == K_PAYLOAD || o_res.field_kind == K_OTHER)
                        o_res.end_of_field = 1'b1;
                    n_phase = PH_FIXHDR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXHDR; r_type <= '0; r_flags <= '0; r_rem <= '0;
            r_left <= '0; r_grp <= '0; r_slen <= '0; r_sleft <= '0;
            r_idx <= '0; r_pid <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_type <= n_type; r_flags <= n_flags; r_rem <= n_rem;
            r_left <= n_left; r_grp <= n_grp; r_slen <= n_slen; r_sleft <= n_sleft;
            r_idx <= n_idx; r_pid <= n_pid;
        end
    end

endmodule

// File: src/mqttd_queue.sv
`timescale 1ns / 1ps
module mqttd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  mqttd_pkg::t_result i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_rd,
    output mqttd_pkg::t_result o_data
);
    import mqttd_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

// File: src/mqttd_checker.sv
`timescale 1ns / 1ps
module mqttd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_fix_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11:8] == 4'd0 |-> m_axis_tdata[72])
        else $error("fixed header must end its field");
    a_err_noend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[75:74] != 2'd0
        |-> !m_axis_tdata[72] && !m_axis_tdata[73])
        else $error("error byte marked as end");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted byte gave no result");
endmodule

bind mqtt_packet_deframer_core mqttd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
